// ----- src/qer_pkg.sv -----
package qer_pkg;

  localparam int POLY_WIDTH   = 47;
  localparam int ROOT_WIDTH   = 18;
  localparam int STATUS_WIDTH = 2;

  localparam logic [STATUS_WIDTH-1:0] ROOT_REAL      = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ROOT_IMAGINARY = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] ROOT_LEAD_ZERO = 2'd2;

endpackage

// ----- src/quadratic_eval_and_roots_unit.sv -----
// Quadratic evaluator and root solver. Each transaction carries a, b, c and x and
// returns a*x*x+b*x+c, a root status and the two roots (-b +/- sqrt(b*b-4ac))/(2a),
// truncated toward zero, with sqrt carrying SQRT_FRACTION_BITS fraction bits.
// The unit is fully pipelined and takes one transaction every cycle. The pipeline is
// made of three stages of products and the discriminant, a load stage plus one stage
// per root bit of the restoring square root (COEF_WIDTH+2+SQRT_FRACTION_BITS in all),
// a load stage plus one stage per quotient bit of the two restoring dividers
// (COEF_WIDTH+2 in all), and the output register. The whole pipeline holds while a
// result waits on out_ready, so in_ready falls only then.
module quadratic_eval_and_roots_unit #(
  parameter int COEF_WIDTH         = 16,
  parameter int SQRT_FRACTION_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [COEF_WIDTH-1:0]           in_coef_square,
  input  logic signed [COEF_WIDTH-1:0]           in_coef_linear,
  input  logic signed [COEF_WIDTH-1:0]           in_coef_constant,
  input  logic signed [COEF_WIDTH-1:0]           in_point,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [qer_pkg::POLY_WIDTH-1:0]  out_poly_value,
  output logic [qer_pkg::STATUS_WIDTH-1:0]       out_root_status,
  output logic signed [qer_pkg::ROOT_WIDTH-1:0]  out_root_plus,
  output logic signed [qer_pkg::ROOT_WIDTH-1:0]  out_root_minus
);
  import qer_pkg::*;

  localparam int W    = COEF_WIDTH;
  localparam int F    = SQRT_FRACTION_BITS;
  localparam int RB   = W + 1 + F;
  localparam int QN   = W + 1;
  localparam int DW   = 2 * W + 2;
  localparam int PW   = 3 * W + 1;
  localparam int PEW  = (PW > POLY_WIDTH) ? PW : POLY_WIDTH + 1;
  localparam int NUMW = W + F + 3;
  localparam int CW   = (QN + 1 > ROOT_WIDTH + 1) ? QN + 1 : ROOT_WIDTH + 1;

  localparam logic signed [PEW-1:0] PMAX = PEW'(47'sh3FFF_FFFF_FFFF);
  localparam logic signed [PEW-1:0] PMIN = -PMAX - PEW'(1);
  localparam logic signed [CW-1:0]  RLIM = CW'(131072);
  localparam logic signed [CW-1:0]  RMAX = CW'(131071);

  typedef struct packed {
    logic [STATUS_WIDTH-1:0]      status;
    logic signed [POLY_WIDTH-1:0] poly;
    logic                         a_neg;
    logic [W-1:0]                 a_mag;
    logic signed [W-1:0]          b;
  } side_t;

  logic en;

  // Front stages.
  logic v1_r, v2_r, v3_r;
  logic signed [W-1:0]    a1_r, b1_r, c1_r, x1_r;
  logic signed [2*W-1:0]  ax2_r, bb2_r, ac2_r, bx2_r;
  logic signed [W-1:0]    a2_r, b2_r, c2_r, x2_r;
  logic signed [PW-1:0]   axx3_r;
  logic signed [2*W:0]    bxc3_r;
  logic signed [DW-1:0]   d3_r;
  logic signed [W-1:0]    a3_r, b3_r;

  // Square root stages.
  logic            sq_v_r    [0:RB];
  logic [2*RB-1:0] sq_rad_r  [0:RB];
  logic [RB:0]     sq_rem_r  [0:RB];
  logic [RB-1:0]   sq_root_r [0:RB];
  side_t           sq_side_r [0:RB];
  logic [2*RB-1:0] sq_rad_nxt  [1:RB];
  logic [RB:0]     sq_rem_nxt  [1:RB];
  logic [RB-1:0]   sq_root_nxt [1:RB];

  // Divider stages.
  logic          dv_v_r    [0:QN];
  logic [W-1:0]  dv_prem_r [0:QN];
  logic [QN-1:0] dv_pq_r   [0:QN];
  logic [W-1:0]  dv_mrem_r [0:QN];
  logic [QN-1:0] dv_mq_r   [0:QN];
  logic          dv_pneg_r [0:QN];
  logic          dv_mneg_r [0:QN];
  side_t         dv_side_r [0:QN];
  logic [W-1:0]  dv_prem_nxt [1:QN];
  logic [QN-1:0] dv_pq_nxt   [1:QN];
  logic [W-1:0]  dv_mrem_nxt [1:QN];
  logic [QN-1:0] dv_mq_nxt   [1:QN];

  logic out_valid_r;
  logic signed [POLY_WIDTH-1:0] out_poly_r;
  logic [STATUS_WIDTH-1:0]      out_status_r;
  logic signed [ROOT_WIDTH-1:0] out_plus_r, out_minus_r;

  side_t          side_nxt;
  logic signed [PEW-1:0] poly_ext;
  logic signed [NUMW-1:0] nbs, np, nm, np_mag, nm_mag;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Entry of the root pipeline: status, saturated polynomial value and |a|.
  always_comb begin
    poly_ext        = PEW'(axx3_r) + PEW'(bxc3_r);
    side_nxt.poly   = (poly_ext > PMAX) ? POLY_WIDTH'(PMAX) :
                      (poly_ext < PMIN) ? POLY_WIDTH'(PMIN) : POLY_WIDTH'(poly_ext);
    if (a3_r == '0) begin
      side_nxt.status = ROOT_LEAD_ZERO;
    end else if (d3_r < 0) begin
      side_nxt.status = ROOT_IMAGINARY;
    end else begin
      side_nxt.status = ROOT_REAL;
    end
    side_nxt.a_neg = a3_r[W-1];
    side_nxt.a_mag = a3_r[W-1] ? W'(-a3_r) : W'(a3_r);
    side_nxt.b     = b3_r;
  end

  // One root bit per stage, one radicand bit pair shifted in from the top.
  always_comb begin
    logic [RB+2:0] remsh;
    logic [RB+2:0] trial;
    for (int k = 0; k < RB; k++) begin
      remsh = {sq_rem_r[k], sq_rad_r[k][2*RB-1 -: 2]};
      trial = (RB+3)'({sq_root_r[k], 2'b01});
      sq_rad_nxt[k+1] = sq_rad_r[k] << 2;
      if (remsh >= trial) begin
        sq_rem_nxt[k+1]  = (RB+1)'(remsh - trial);
        sq_root_nxt[k+1] = {sq_root_r[k][RB-2:0], 1'b1};
      end else begin
        sq_rem_nxt[k+1]  = (RB+1)'(remsh);
        sq_root_nxt[k+1] = {sq_root_r[k][RB-2:0], 1'b0};
      end
    end
  end

  // Numerators. Dividing by 2|a|*2^F equals shifting right by F+1 and dividing by |a|.
  always_comb begin
    nbs    = (-NUMW'(sq_side_r[RB].b)) <<< F;
    np     = nbs + NUMW'(sq_root_r[RB]);
    nm     = nbs - NUMW'(sq_root_r[RB]);
    np_mag = np[NUMW-1] ? -np : np;
    nm_mag = nm[NUMW-1] ? -nm : nm;
  end

  // One quotient bit per stage for both roots.
  always_comb begin
    logic [W:0] prs;
    logic [W:0] mrs;
    logic [W:0] dvs;
    for (int k = 0; k < QN; k++) begin
      dvs = {1'b0, dv_side_r[k].a_mag};
      prs = {dv_prem_r[k], dv_pq_r[k][QN-1]};
      mrs = {dv_mrem_r[k], dv_mq_r[k][QN-1]};
      if (prs >= dvs) begin
        dv_prem_nxt[k+1] = W'(prs - dvs);
        dv_pq_nxt[k+1]   = {dv_pq_r[k][QN-2:0], 1'b1};
      end else begin
        dv_prem_nxt[k+1] = W'(prs);
        dv_pq_nxt[k+1]   = {dv_pq_r[k][QN-2:0], 1'b0};
      end
      if (mrs >= dvs) begin
        dv_mrem_nxt[k+1] = W'(mrs - dvs);
        dv_mq_nxt[k+1]   = {dv_mq_r[k][QN-2:0], 1'b1};
      end else begin
        dv_mrem_nxt[k+1] = W'(mrs);
        dv_mq_nxt[k+1]   = {dv_mq_r[k][QN-2:0], 1'b0};
      end
    end
  end

  function automatic logic signed [ROOT_WIDTH-1:0] sat_root(input logic [QN-1:0] q,
                                                           input logic neg);
    logic signed [CW-1:0] qe;
    logic signed [CW-1:0] qs;
    qe = CW'(q);
    qs = (qe > RLIM) ? RLIM : qe;
    if (neg) begin
      qs = -qs;
    end else if (qs > RMAX) begin
      qs = RMAX;
    end
    return ROOT_WIDTH'(qs);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k <= RB; k++) sq_v_r[k] <= 1'b0;
      for (int k = 0; k <= QN; k++) dv_v_r[k] <= 1'b0;
    end else if (en) begin
      v1_r      <= in_valid;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      sq_v_r[0] <= v3_r;
      for (int k = 0; k < RB; k++) sq_v_r[k+1] <= sq_v_r[k];
      dv_v_r[0] <= sq_v_r[RB];
      for (int k = 0; k < QN; k++) dv_v_r[k+1] <= dv_v_r[k];
      out_valid_r <= dv_v_r[QN];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r <= in_coef_square;
      b1_r <= in_coef_linear;
      c1_r <= in_coef_constant;
      x1_r <= in_point;

      ax2_r <= a1_r * x1_r;
      bb2_r <= b1_r * b1_r;
      ac2_r <= a1_r * c1_r;
      bx2_r <= b1_r * x1_r;
      a2_r  <= a1_r;
      b2_r  <= b1_r;
      c2_r  <= c1_r;
      x2_r  <= x1_r;

      axx3_r <= PW'(ax2_r) * PW'(x2_r);
      bxc3_r <= (2*W+1)'(bx2_r) + (2*W+1)'(c2_r);
      d3_r   <= DW'(bb2_r) - (DW'(ac2_r) <<< 2);
      a3_r   <= a2_r;
      b3_r   <= b2_r;

      sq_rad_r[0]  <= (2*RB)'(d3_r[DW-1:0]) << (2 * F);
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_side_r[0] <= side_nxt;
      for (int k = 0; k < RB; k++) begin
        sq_rad_r[k+1]  <= sq_rad_nxt[k+1];
        sq_rem_r[k+1]  <= sq_rem_nxt[k+1];
        sq_root_r[k+1] <= sq_root_nxt[k+1];
        sq_side_r[k+1] <= sq_side_r[k];
      end

      dv_prem_r[0] <= '0;
      dv_mrem_r[0] <= '0;
      dv_pq_r[0]   <= QN'(np_mag >>> (F + 1));
      dv_mq_r[0]   <= QN'(nm_mag >>> (F + 1));
      dv_pneg_r[0] <= np[NUMW-1] ^ sq_side_r[RB].a_neg;
      dv_mneg_r[0] <= nm[NUMW-1] ^ sq_side_r[RB].a_neg;
      dv_side_r[0] <= sq_side_r[RB];
      for (int k = 0; k < QN; k++) begin
        dv_prem_r[k+1] <= dv_prem_nxt[k+1];
        dv_pq_r[k+1]   <= dv_pq_nxt[k+1];
        dv_mrem_r[k+1] <= dv_mrem_nxt[k+1];
        dv_mq_r[k+1]   <= dv_mq_nxt[k+1];
        dv_pneg_r[k+1] <= dv_pneg_r[k];
        dv_mneg_r[k+1] <= dv_mneg_r[k];
        dv_side_r[k+1] <= dv_side_r[k];
      end

      out_poly_r   <= dv_side_r[QN].poly;
      out_status_r <= dv_side_r[QN].status;
      if (dv_side_r[QN].status == ROOT_REAL) begin
        out_plus_r  <= sat_root(dv_pq_r[QN], dv_pneg_r[QN]);
        out_minus_r <= sat_root(dv_mq_r[QN], dv_mneg_r[QN]);
      end else begin
        out_plus_r  <= '0;
        out_minus_r <= '0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_poly_value  = out_poly_r;
  assign out_root_status = out_status_r;
  assign out_root_plus   = out_plus_r;
  assign out_root_minus  = out_minus_r;

`ifndef SYNTHESIS
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled result");

  a_roots_zero_unless_real: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_root_status != ROOT_REAL |-> out_root_plus == '0 && out_root_minus == '0)
    else $error("root fields nonzero for non-real status");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_root_status == ROOT_REAL || out_root_status == ROOT_IMAGINARY ||
                  out_root_status == ROOT_LEAD_ZERO)
    else $error("undefined root status");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
`endif

endmodule

// ----- test/tb_quadratic_eval_and_roots_unit.sv -----
module tb_quadratic_eval_and_roots_unit;
  import qer_pkg::*;

  localparam int CW = 16;
  localparam int FB = 16;
  localparam int N_RANDOM = 1530;
  localparam int QUIET_TAIL = 200;
  localparam int STALL_LIMIT = 4000;
  localparam longint POLY_HI = (64'sd1 <<< (POLY_WIDTH - 1)) - 1;
  localparam longint POLY_LO = -POLY_HI - 1;
  localparam longint ROOT_HI = (64'sd1 <<< (ROOT_WIDTH - 1)) - 1;
  localparam longint ROOT_LO = -ROOT_HI - 1;

  typedef struct {
    logic signed [POLY_WIDTH-1:0] poly;
    logic [STATUS_WIDTH-1:0]      status;
    logic signed [ROOT_WIDTH-1:0] rplus;
    logic signed [ROOT_WIDTH-1:0] rminus;
  } solution_t;

  // Floor of sqrt(d * 4^FB), one root bit per step.
  function automatic longint unsigned fixed_root(longint unsigned d);
    logic [127:0] rad;
    logic [127:0] rem;
    logic [127:0] root;
    logic [127:0] trial;
    rad = 128'(d) << (2 * FB);
    rem = '0;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 2) | 128'(rad[2*i +: 2]);
      trial = (root << 2) | 128'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 128'd1;
      end else begin
        root = root << 1;
      end
    end
    return root[63:0];
  endfunction

  function automatic longint clip_root(longint v);
    return v < ROOT_LO ? ROOT_LO : (v > ROOT_HI ? ROOT_HI : v);
  endfunction

  function automatic solution_t solve_quadratic(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
                                                logic signed [CW-1:0] c, logic signed [CW-1:0] x);
    solution_t r;
    longint la, lb, lc, lx, pv, disc, s, nb, den;
    la = a; lb = b; lc = c; lx = x;
    pv = la * lx * lx + lb * lx + lc;
    pv = pv < POLY_LO ? POLY_LO : (pv > POLY_HI ? POLY_HI : pv);
    r.poly = pv[POLY_WIDTH-1:0];
    r.rplus = '0;
    r.rminus = '0;
    disc = lb * lb - 4 * la * lc;
    if (la == 0) begin
      r.status = ROOT_LEAD_ZERO;
    end else if (disc < 0) begin
      r.status = ROOT_IMAGINARY;
    end else begin
      r.status = ROOT_REAL;
      s = longint'(fixed_root(longint'(disc)));
      nb = -lb * (64'sd1 <<< FB);
      den = 2 * la * (64'sd1 <<< FB);
      // Signed longint division already truncates toward zero.
      r.rplus = clip_root((nb + s) / den);
      r.rminus = clip_root((nb - s) / den);
    end
    return r;
  endfunction

  class solution_board;
    solution_t pending[$];
    int errors = 0;

    function void note_equation(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
                                logic signed [CW-1:0] c, logic signed [CW-1:0] x);
      pending.push_back(solve_quadratic(a, b, c, x));
    endfunction

    function void check_solution(solution_t got);
      solution_t want;
      if (pending.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.poly !== want.poly) begin
        $error("poly_value expected %0d actual %0d", want.poly, got.poly);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("root_status expected %0d actual %0d", want.status, got.status);
        errors++;
      end
      if (got.rplus !== want.rplus) begin
        $error("root_plus expected %0d actual %0d", want.rplus, got.rplus);
        errors++;
      end
      if (got.rminus !== want.rminus) begin
        $error("root_minus expected %0d actual %0d", want.rminus, got.rminus);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CW-1:0] in_coef_square = '0;
  logic signed [CW-1:0] in_coef_linear = '0;
  logic signed [CW-1:0] in_coef_constant = '0;
  logic signed [CW-1:0] in_point = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [POLY_WIDTH-1:0] out_poly_value;
  logic [STATUS_WIDTH-1:0] out_root_status;
  logic signed [ROOT_WIDTH-1:0] out_root_plus;
  logic signed [ROOT_WIDTH-1:0] out_root_minus;

  solution_board board = new();
  bit quiet = 1'b0;
  int idle_cycles = 0;
  bit in_fire, out_fire;

  quadratic_eval_and_roots_unit #(.COEF_WIDTH(CW), .SQRT_FRACTION_BITS(FB)) dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // Handshakes are sampled at the falling edge, where every signal is settled,
  // and take effect at the following rising edge.
  always @(negedge clk) begin
    in_fire = rst_n && in_valid && in_ready;
    out_fire = rst_n && out_valid && out_ready;
    if (out_fire)
      board.check_solution('{out_poly_value, out_root_status, out_root_plus, out_root_minus});
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_fire || out_fire) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // The receiver stalls in random bursts, none during the quiet tail.
  initial begin
    int burst;
    @(posedge rst_n);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 5);
        out_ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_equation(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
                               logic signed [CW-1:0] c, logic signed [CW-1:0] x);
    bit taken;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_coef_square <= a;
    in_coef_linear <= b;
    in_coef_constant <= c;
    in_point <= x;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    board.note_equation(a, b, c, x);
  endtask

  function automatic logic signed [CW-1:0] pick_coef(int mode);
    case (mode)
      0: return CW'($urandom);
      1: return CW'(int'($urandom_range(0, 40)) - 20);
      2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return CW'(int'($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  task automatic send_random();
    logic signed [CW-1:0] a, b, c, x;
    a = pick_coef($urandom_range(0, 3));
    b = pick_coef($urandom_range(0, 3));
    c = pick_coef($urandom_range(0, 3));
    x = pick_coef($urandom_range(0, 3));
    if ($urandom_range(0, 9) == 0) a = '0;
    // Build equations with a perfect-square discriminant from chosen roots.
    if ($urandom_range(0, 4) == 0) begin
      int r1, r2, k;
      r1 = $urandom_range(0, 200) - 100;
      r2 = $urandom_range(0, 200) - 100;
      k = $urandom_range(1, 3);
      a = CW'(k);
      b = CW'(-k * (r1 + r2));
      c = CW'(k * r1 * r2);
    end
    send_equation(a, b, c, x);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: field extremes, zero leading coefficient, negative and zero discriminant.
    send_equation(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_equation(16'sd0, 16'sd5, 16'sd3, 16'sd7);
    send_equation(16'sd0, 16'sh8000, 16'sh7fff, 16'sh8000);
    send_equation(16'sd1, 16'sd0, 16'sd1, 16'sd2);
    send_equation(16'sd1, 16'sd2, 16'sd1, -16'sd1);
    send_equation(16'sd1, -16'sd3, 16'sd2, 16'sd3);
    send_equation(16'sd2, 16'sd1, -16'sd1, 16'sd1);
    send_equation(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_equation(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_equation(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
    send_equation(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000);
    send_equation(16'sh7fff, 16'sd0, 16'sh7fff, 16'sh8000);
    send_equation(16'sd1, 16'sh8000, 16'sd0, 16'sh7fff);
    send_equation(-16'sd1, 16'sh7fff, 16'sh7fff, 16'sd1);
    send_equation(16'sd1, 16'sd0, 16'sh8000, 16'sd0);
    send_equation(16'sd3, 16'sd0, 16'sd0, -16'sd1);
    send_equation(-16'sd1, 16'sd0, 16'sd0, 16'sd0);
    send_equation(16'shffff, 16'shffff, 16'shffff, 16'shffff);
    send_equation(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa);
    send_equation(16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - QUIET_TAIL) quiet = 1'b1;
      send_random();
    end
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
